// ===== hdl/mat_pkg.sv =====
// ----------------------------------------------------------------------------
// mat_pkg
// shared widths, codes and the request type of the message ack table
// ----------------------------------------------------------------------------
`default_nettype none

package mat_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int MAX_NODES   = 16;
  localparam int LIST_CAP    = MAX_NODES - 1;

  localparam int ENTRY_W = $clog2(TABLE_DEPTH);
  localparam int SLOT_W  = $clog2(MAX_NODES);
  localparam int CNT_W   = SLOT_W;
  localparam int ADDR_W  = ENTRY_W + SLOT_W;
  localparam int MEM_DEPTH = TABLE_DEPTH * (1 << SLOT_W);

  // field widths
  localparam int CMD_W    = 3;
  localparam int NODE_W   = 8;
  localparam int ID_W     = 32;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_BCAST = 1'b0;
  localparam logic [NODE_W-1:0] BCAST_RESET = 8'hFF;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SAVE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DUP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CNT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NODE = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef enum logic [2:0] {
    OP_SAVE,
    OP_ACK,
    OP_DUP,
    OP_CNT,
    OP_NODE,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [NODE_W-1:0] sender;
    logic [NODE_W-1:0] receiver;
    logic [ID_W-1:0]   message_id;
    logic [IDX_W-1:0]  ack_index;
  } req_t;

endpackage

`default_nettype wire

// ===== hdl/mat_front.sv =====
// ----------------------------------------------------------------------------
// mat_front
// takes requests, decodes the command and hands them to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module mat_front
  import mat_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [NODE_W-1:0] sender,
  input  wire logic [NODE_W-1:0] receiver,
  input  wire logic [ID_W-1:0]   message_id,
  input  wire logic [IDX_W-1:0]  ack_index,
  input  wire logic              q_full,
  output logic                   push,
  output req_t                   req
);

  logic front_valid;
  logic accept;
  op_t  op_dec;

  always_comb begin
    unique case (command)
      CMD_SAVE: op_dec = OP_SAVE;
      CMD_ACK:  op_dec = OP_ACK;
      CMD_DUP:  op_dec = OP_DUP;
      CMD_CNT:  op_dec = OP_CNT;
      CMD_NODE: op_dec = OP_NODE;
      default:  op_dec = OP_NONE;
    endcase
  end

  assign busy   = front_valid && q_full;
  assign accept = start && !busy;
  assign push   = front_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= accept || (front_valid && !push);
    end
  end

  // request holding register
  always_ff @(posedge clk) begin
    if (accept) begin
      req.op         <= op_dec;
      req.sender     <= sender;
      req.receiver   <= receiver;
      req.message_id <= message_id;
      req.ack_index  <= ack_index;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mat_queue.sv =====
// ----------------------------------------------------------------------------
// mat_queue
// short request fifo between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module mat_queue
  import mat_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire req_t push_req,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output req_t      head
);

  req_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mat_back.sv =====
// ----------------------------------------------------------------------------
// mat_back
// executes requests: entry table, ack list memory and the scan sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module mat_back
  import mat_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [NODE_W-1:0]   bcast,
  input  wire logic                q_empty,
  input  wire req_t                q_head,
  output logic                     pop,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic [COUNT_W-1:0]       ack_count,
  output logic [NODE_W-1:0]        ack_node
);

  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SAVE,
    S_SCAN,
    S_LIST,
    S_FINISH,
    S_NODE_WAIT
  } state_t;

  state_t state;
  req_t   cur;

  // entry table
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [NODE_W-1:0]      entry_sender   [TABLE_DEPTH];
  logic [NODE_W-1:0]      entry_receiver [TABLE_DEPTH];
  logic [ID_W-1:0]        entry_id       [TABLE_DEPTH];
  logic [CNT_W-1:0]       entry_ack_count [TABLE_DEPTH];
  logic [ENTRY_W-1:0]     write_pointer;

  // ack list memory
  logic [NODE_W-1:0] ack_mem [MEM_DEPTH];
  logic [NODE_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              mem_we;

  // scan state
  logic [ENTRY_W-1:0] e;
  logic [CNT_W-1:0]   j;
  logic               rd_valid;
  logic               found;
  logic               added;
  logic               full;
  logic [ENTRY_W-1:0] sel_e;
  logic [CNT_W-1:0]   sel_cnt;

  logic id_hit, ack_hit, dup_hit, qry_hit, scan_hit;
  logic last_e, last_wp;
  logic list_found, list_more, room, node_in_range;

  assign id_hit  = (entry_id[e] == cur.message_id);
  assign ack_hit = entry_valid[e] && id_hit &&
                   ((entry_receiver[e] == cur.sender) || (entry_receiver[e] == bcast));
  assign dup_hit = entry_valid[e] && id_hit && (entry_sender[e] == cur.sender);
  assign qry_hit = entry_valid[e] && id_hit && (entry_receiver[e] == cur.sender);
  assign scan_hit = (cur.op == OP_DUP) ? dup_hit : qry_hit;

  assign last_e  = (e == ENTRY_W'(TABLE_DEPTH - 1));
  assign last_wp = (write_pointer == ENTRY_W'(TABLE_DEPTH - 1));

  assign list_found = rd_valid && (rd_data == cur.sender);
  assign list_more  = (j < entry_ack_count[e]);
  assign room       = (entry_ack_count[e] < CNT_W'(LIST_CAP));
  assign node_in_range = (CMP_W'(cur.ack_index) < CMP_W'(sel_cnt));

  assign pop    = (state == S_IDLE) && !q_empty;
  assign mem_we = (state == S_LIST) && !rd_valid && !list_more && room;
  assign wr_addr = {e, entry_ack_count[e]};
  assign rd_addr = (state == S_LIST) ? {e, j} : {sel_e, SLOT_W'(cur.ack_index)};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ack_mem[wr_addr] <= cur.sender;
    end
    rd_data <= ack_mem[rd_addr];
  end

  // request and entry payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
    if (state == S_SAVE) begin
      entry_sender[write_pointer]   <= cur.sender;
      entry_receiver[write_pointer] <= cur.receiver;
      entry_id[write_pointer]       <= cur.message_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_valid   <= '0;
      write_pointer <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        entry_ack_count[i] <= '0;
      end
      e         <= '0;
      j         <= '0;
      rd_valid  <= 1'b0;
      found     <= 1'b0;
      added     <= 1'b0;
      full      <= 1'b0;
      sel_e     <= '0;
      sel_cnt   <= '0;
      done      <= 1'b0;
      status    <= ST_OK;
      ack_count <= '0;
      ack_node  <= '0;
    end else begin
      done     <= 1'b0;
      rd_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            unique case (q_head.op) inside
              OP_SAVE: begin
                state <= S_SAVE;
              end
              OP_ACK, OP_DUP, OP_CNT, OP_NODE: begin
                state <= S_SCAN;
                e     <= '0;
                found <= 1'b0;
                added <= 1'b0;
                full  <= 1'b0;
              end
              default: begin
                done      <= 1'b1;
                status    <= ST_NOT_FOUND;
                ack_count <= '0;
                ack_node  <= '0;
              end
            endcase
          end
        end
        S_SAVE: begin
          entry_valid[write_pointer]     <= 1'b1;
          entry_ack_count[write_pointer] <= '0;
          write_pointer <= last_wp ? '0 : write_pointer + 1'b1;
          done      <= 1'b1;
          status    <= ST_OK;
          ack_count <= '0;
          ack_node  <= '0;
          state     <= S_IDLE;
        end
        S_SCAN: begin
          if (cur.op == OP_ACK && ack_hit) begin
            state <= S_LIST;
            j     <= '0;
          end else begin
            if (cur.op != OP_ACK) begin
              found <= found || scan_hit;
              if (scan_hit && (cur.op == OP_NODE || !found)) begin
                sel_e   <= e;
                sel_cnt <= entry_ack_count[e];
              end
            end
            if (last_e) begin
              state <= S_FINISH;
            end else begin
              e <= e + 1'b1;
            end
          end
        end
        S_LIST: begin
          if (list_found || (!rd_valid && !list_more)) begin
            if (!list_found) begin
              if (room) begin
                entry_ack_count[e] <= entry_ack_count[e] + 1'b1;
                added <= 1'b1;
              end else begin
                full <= 1'b1;
              end
            end
            if (last_e) begin
              state <= S_FINISH;
            end else begin
              e     <= e + 1'b1;
              state <= S_SCAN;
            end
          end else if (list_more) begin
            j        <= j + 1'b1;
            rd_valid <= 1'b1;
          end
        end
        S_FINISH: begin
          ack_count <= '0;
          ack_node  <= '0;
          state     <= S_IDLE;
          unique case (cur.op) inside
            OP_ACK: begin
              done   <= 1'b1;
              status <= added ? ST_OK : (full ? ST_FULL : ST_NOT_FOUND);
            end
            OP_DUP: begin
              done   <= 1'b1;
              status <= found ? ST_DUPLICATE : ST_NOT_FOUND;
            end
            OP_CNT: begin
              done      <= 1'b1;
              status    <= found ? ST_OK : ST_NOT_FOUND;
              ack_count <= found ? COUNT_W'(sel_cnt) : '0;
            end
            OP_NODE: begin
              if (found && node_in_range) begin
                state <= S_NODE_WAIT;
              end else begin
                done   <= 1'b1;
                status <= found ? ST_OK : ST_NOT_FOUND;
              end
            end
            default: begin
              done   <= 1'b1;
              status <= ST_NOT_FOUND;
            end
          endcase
        end
        S_NODE_WAIT: begin
          done      <= 1'b1;
          status    <= ST_OK;
          ack_count <= '0;
          ack_node  <= rd_data;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/message_ack_table.sv =====
// ----------------------------------------------------------------------------
// message_ack_table
// ring table of recent radio messages with per-message acknowledgment lists
// ----------------------------------------------------------------------------
// request: command and its fields with start high, taken at a rising edge
//   where start is high and busy is low
// result: done high for exactly one cycle with status, ack_count and
//   ack_node; the receiver cannot stall, each result is taken in that cycle
// config: apb-style, broadcast_address at byte address 0, pready tied high
// steps: the request passes the front register and the queue; the back
//   end then answers an unknown command from idle and a save from its save
//   state; duplicate check and ack count scan all TABLE_DEPTH entries (one
//   entry a cycle); ack node does the same scan plus one extra ack memory
//   read when ack_index lies inside the list; record ack scans the table
//   and, per matching entry, walks its list in the ack memory
// throughput: one request at a time in the back end, set by the entry scan
//   and the single ack memory port; a front register and a two-deep queue
//   take further requests meanwhile, busy rises once both are occupied
// reset: synchronous rst empties the queue, clears valid bits, ack counts
//   and the write pointer, sets broadcast_address to 255; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module message_ack_table
  import mat_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // request channel
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    command,
  input  wire logic [NODE_W-1:0]   sender,
  input  wire logic [NODE_W-1:0]   receiver,
  input  wire logic [ID_W-1:0]     message_id,
  input  wire logic [IDX_W-1:0]    ack_index,
  // result channel
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic [COUNT_W-1:0]       ack_count,
  output logic [NODE_W-1:0]        ack_node,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  logic [NODE_W-1:0] broadcast_address;
  logic              reg_sel;
  logic              cfg_write;

  // front to queue
  logic q_push;
  req_t front_req;
  logic q_full;

  // queue to back
  logic q_pop;
  logic q_empty;
  req_t q_head;

  // ---------------------------------------------------------------------
  // configuration register: word index is the address above the byte bits
  // ---------------------------------------------------------------------
  assign reg_sel   = (paddr[PADDR_W-1] == REG_BCAST);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = reg_sel ? PDATA_W'(broadcast_address) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      broadcast_address <= BCAST_RESET;
    end else if (cfg_write && reg_sel) begin
      broadcast_address <= pwdata[NODE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // front: takes the request and decodes the command
  // ---------------------------------------------------------------------
  mat_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .sender     (sender),
    .receiver   (receiver),
    .message_id (message_id),
    .ack_index  (ack_index),
    .q_full     (q_full),
    .push       (q_push),
    .req        (front_req)
  );

  // ---------------------------------------------------------------------
  // queue: decouples request intake from the scan sequencer
  // ---------------------------------------------------------------------
  mat_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_req (front_req),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // ---------------------------------------------------------------------
  // back: entry table, ack lists and the scan that answers each request
  // ---------------------------------------------------------------------
  mat_back u_back (
    .clk       (clk),
    .rst       (rst),
    .bcast     (broadcast_address),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (q_pop),
    .done      (done),
    .status    (status),
    .ack_count (ack_count),
    .ack_node  (ack_node)
  );

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------

  // any status other than ok carries empty data fields
  assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (ack_count == '0) && (ack_node == '0))
    else $error("non-ok result with data fields set");

  // the intake only closes after it has taken a request
  assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request being taken");

  // reset leaves the intake open
  assert property (@(posedge clk)
    rst |=> !busy)
    else $error("busy after reset");

endmodule

`default_nettype wire

// ===== test/message_ack_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_ack_table_test
// self-checking bench for the message ack table: a directed set of requests,
// then random bursts of message conversations, list floods and noise; a table
// model in the bench predicts every result and the monitor compares each field
// ----------------------------------------------------------------------------

module message_ack_table_test;
  import mat_pkg::*;

  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 7;
  localparam int SETTLE_CYCLES    = 12;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int RANDOM_PER_PHASE = 85;

  // broadcast register sits at byte address 4 * index
  localparam logic [PADDR_W-1:0] BCAST_PADDR = PADDR_W'(4 * int'(REG_BCAST));

  // command codes the block does not know
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam logic [ID_W-1:0]   ID_TOP   = '1;
  localparam logic [NODE_W-1:0] NODE_TOP = '1;
  localparam logic [IDX_W-1:0]  IDX_TOP  = '1;

  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [NODE_W-1:0] sender;
    logic [NODE_W-1:0] receiver;
    logic [ID_W-1:0]   message_id;
    logic [IDX_W-1:0]  ack_index;
    bit                drain_first;  // hold the request until all results are in
  } msg_request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  ack_count;
    logic [NODE_W-1:0]   ack_node;
  } table_reply_t;

  // clock, reset and block ports
  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                start      = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    command    = '0;
  logic [NODE_W-1:0]   sender     = '0;
  logic [NODE_W-1:0]   receiver   = '0;
  logic [ID_W-1:0]     message_id = '0;
  logic [IDX_W-1:0]    ack_index  = '0;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  ack_count;
  logic [NODE_W-1:0]   ack_node;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [PADDR_W-1:0]  paddr      = '0;
  logic [PDATA_W-1:0]  pwdata     = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  message_ack_table DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .sender     (sender),
    .receiver   (receiver),
    .message_id (message_id),
    .ack_index  (ack_index),
    .done       (done),
    .status     (status),
    .ack_count  (ack_count),
    .ack_node   (ack_node),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin : clock_gen
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // table model: its own copy of every entry, the ack lists and the register
  // --------------------------------------------------------------------------
  bit                  tbl_valid    [TABLE_DEPTH] = '{default: 1'b0};
  logic [NODE_W-1:0]   tbl_sender   [TABLE_DEPTH];
  logic [NODE_W-1:0]   tbl_receiver [TABLE_DEPTH];
  logic [ID_W-1:0]     tbl_id       [TABLE_DEPTH];
  logic [COUNT_W-1:0]  tbl_count    [TABLE_DEPTH] = '{default: '0};
  logic [NODE_W-1:0]   tbl_acks     [TABLE_DEPTH][LIST_CAP];
  int                  wr_ptr    = 0;
  logic [NODE_W-1:0]   bcast_addr = BCAST_RESET;

  // applies one request to the model and returns the result it must give
  function automatic table_reply_t apply_request(msg_request_t r);
    table_reply_t rep;
    bit added;
    bit full;
    bit listed;
    rep.status    = ST_NOT_FOUND;
    rep.ack_count = '0;
    rep.ack_node  = '0;
    added = 1'b0;
    full  = 1'b0;
    case (r.command)
      CMD_SAVE: begin
        tbl_valid[wr_ptr]    = 1'b1;
        tbl_sender[wr_ptr]   = r.sender;
        tbl_receiver[wr_ptr] = r.receiver;
        tbl_id[wr_ptr]       = r.message_id;
        tbl_count[wr_ptr]    = '0;
        wr_ptr = (wr_ptr + 1) % TABLE_DEPTH;
        rep.status = ST_OK;
      end
      CMD_ACK: begin
        for (int e = 0; e < TABLE_DEPTH; e++) begin
          if (!tbl_valid[e] || tbl_id[e] != r.message_id) continue;
          if (tbl_receiver[e] != r.sender && tbl_receiver[e] != bcast_addr) continue;
          // only the filled part of the list is searched
          listed = 1'b0;
          for (int j = 0; j < int'(tbl_count[e]); j++)
            if (tbl_acks[e][j] == r.sender) listed = 1'b1;
          if (listed) continue;
          if (int'(tbl_count[e]) >= LIST_CAP) begin
            full = 1'b1;
            continue;
          end
          tbl_acks[e][tbl_count[e]] = r.sender;
          tbl_count[e] = tbl_count[e] + 1'b1;
          added = 1'b1;
        end
        rep.status = added ? ST_OK : (full ? ST_FULL : ST_NOT_FOUND);
      end
      CMD_DUP: begin
        for (int e = 0; e < TABLE_DEPTH; e++) begin
          if (tbl_valid[e] && tbl_sender[e] == r.sender && tbl_id[e] == r.message_id) begin
            rep.status = ST_DUPLICATE;
            break;
          end
        end
      end
      CMD_CNT: begin
        // first match wins, broadcast entries only match on a literal receiver
        for (int e = 0; e < TABLE_DEPTH; e++) begin
          if (tbl_valid[e] && tbl_receiver[e] == r.sender && tbl_id[e] == r.message_id) begin
            rep.status    = ST_OK;
            rep.ack_count = tbl_count[e];
            break;
          end
        end
      end
      CMD_NODE: begin
        // last match wins
        for (int e = 0; e < TABLE_DEPTH; e++) begin
          if (tbl_valid[e] && tbl_receiver[e] == r.sender && tbl_id[e] == r.message_id) begin
            rep.status   = ST_OK;
            rep.ack_node = (r.ack_index < tbl_count[e]) ? tbl_acks[e][r.ack_index] : '0;
          end
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // request driver: bursts of random length with random gaps between them
  // --------------------------------------------------------------------------
  msg_request_t request_queue[$];
  table_reply_t pending_replies[$];
  msg_request_t in_flight = '{default: '0};
  int           burst_left = 4;
  int           gap_left   = 0;

  always @(posedge clk) begin : request_driver
    logic next_start;
    if (rst) begin
      start <= 1'b0;
    end else begin
      // request taken at this edge: predict its result now, in issue order
      if (start && !busy) pending_replies.push_back(apply_request(in_flight));
      next_start = start && busy;
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_queue.size() != 0 &&
                     !(request_queue[0].drain_first && pending_replies.size() != 0)) begin
          in_flight  = request_queue.pop_front();
          next_start = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            // now and then a long run with no gaps at all
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
            gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 9);
          end
        end
      end
      start      <= next_start;
      command    <= in_flight.command;
      sender     <= in_flight.sender;
      receiver   <= in_flight.receiver;
      message_id <= in_flight.message_id;
      ack_index  <= in_flight.ack_index;
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: the block cannot be stalled, each done cycle is a result
  // --------------------------------------------------------------------------
  int fail_count = 0;

  always @(posedge clk) begin : reply_monitor
    table_reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $error("result with no request outstanding: status %0d", status);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (ack_count !== want.ack_count) begin
          $error("ack_count: expected %0d, got %0d", want.ack_count, ack_count);
          fail_count++;
        end
        if (ack_node !== want.ack_node) begin
          $error("ack_node: expected %0d, got %0d", want.ack_node, ack_node);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  int cycle_count = 0;

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  logic [NODE_W-1:0] node_pool [6];
  logic [ID_W-1:0]   id_pool   [4];
  int                queued_total = 0;

  function automatic void push_request(logic [CMD_W-1:0] cmd, logic [NODE_W-1:0] snd,
                                       logic [NODE_W-1:0] rcv, logic [ID_W-1:0] id,
                                       logic [IDX_W-1:0] idx, bit drain = 1'b0);
    msg_request_t r;
    r.command     = cmd;
    r.sender      = snd;
    r.receiver    = rcv;
    r.message_id  = id;
    r.ack_index   = idx;
    r.drain_first = drain || ($urandom_range(0, 39) == 0);
    request_queue.push_back(r);
    queued_total++;
  endfunction

  // mostly a small set of nodes so that acks and queries find their entries
  function automatic logic [NODE_W-1:0] pick_node();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return NODE_TOP;
      2:       return bcast_addr;
      default: return node_pool[$urandom_range(0, 5)];
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ID_TOP;
      default: return id_pool[$urandom_range(0, 3)];
    endcase
  endfunction

  // one broadcast message acked by more nodes than its list holds,
  // then a repeat of the first acker and reads at the list's end
  function automatic void push_flood();
    logic [ID_W-1:0]   id;
    logic [NODE_W-1:0] base;
    id   = $urandom();
    base = NODE_W'($urandom_range(0, 200));
    push_request(CMD_SAVE, pick_node(), bcast_addr, id, '0);
    for (int k = 0; k <= LIST_CAP; k++)
      push_request(CMD_ACK, base + NODE_W'(k), '0, id, '0);
    push_request(CMD_ACK, base, '0, id, '0);
    push_request(CMD_CNT, bcast_addr, '0, id, '0);
    push_request(CMD_NODE, bcast_addr, '0, id, IDX_W'(LIST_CAP - 1));
    push_request(CMD_NODE, bcast_addr, '0, id, IDX_TOP);
  endfunction

  function automatic void push_random(int n);
    int                stop_at;
    int                kind;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [ID_W-1:0]   id;
    stop_at = queued_total + n;
    while (queued_total < stop_at) begin
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
        // a message's life: save, a few acks, then the queries about it
        src = pick_node();
        dst = ($urandom_range(0, 2) == 0) ? bcast_addr : pick_node();
        id  = pick_id();
        push_request(CMD_SAVE, src, dst, id, IDX_W'($urandom()));
        repeat ($urandom_range(1, 8))
          push_request(CMD_ACK, ($urandom_range(0, 1) == 0) ? dst : pick_node(),
                       NODE_W'($urandom()), id, IDX_W'($urandom()));
        push_request(CMD_DUP, ($urandom_range(0, 3) == 0) ? pick_node() : src,
                     NODE_W'($urandom()), id, IDX_W'($urandom()));
        push_request(CMD_CNT, dst, NODE_W'($urandom()), id, IDX_W'($urandom()));
        push_request(CMD_NODE, dst, NODE_W'($urandom()), id, IDX_W'($urandom()));
      end else if (kind == 13) begin
        push_flood();
      end else begin
        // noise: any command, fully random fields
        repeat ($urandom_range(1, 4))
          push_request(CMD_W'($urandom_range(0, 7)), NODE_W'($urandom()),
                       NODE_W'($urandom()), $urandom(), IDX_W'($urandom()));
      end
    end
  endfunction

  // wait until every request is issued and answered, then let the block settle
  task automatic wait_idle();
    while (request_queue.size() != 0 || start || pending_replies.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write of the broadcast register; upper data bits carry junk
  task automatic write_broadcast(logic [NODE_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BCAST_PADDR;
    pwdata  <= PDATA_W'({$urandom(), value});
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    bcast_addr = value;
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (node_pool[i]) node_pool[i] = NODE_W'($urandom());
    foreach (id_pool[i]) id_pool[i] = $urandom();

    // directed part, broadcast at its reset value
    push_request(CMD_SPARE_LO, NODE_TOP, NODE_TOP, ID_TOP, IDX_TOP);
    push_request(CMD_SPARE_HI, '0, '0, '0, '0);
    push_request(CMD_DUP, '0, '0, '0, '0);                 // empty table
    push_request(CMD_SAVE, '0, NODE_TOP, '0, '0);          // to broadcast
    push_request(CMD_SAVE, NODE_TOP, '0, ID_TOP, IDX_TOP);
    push_request(CMD_ACK, 8'd7, '0, '0, '0);               // via broadcast
    push_request(CMD_ACK, 8'd7, '0, '0, '0);               // already listed
    push_request(CMD_ACK, '0, NODE_TOP, ID_TOP, '0);       // addressed node
    push_request(CMD_ACK, 8'd9, '0, ID_TOP, '0);           // wrong node
    push_request(CMD_DUP, '0, '0, '0, '0, 1'b1);           // drained first
    push_request(CMD_DUP, NODE_TOP, '0, ID_TOP, '0);
    push_request(CMD_DUP, '0, '0, ID_TOP, '0);             // id of another sender
    push_request(CMD_CNT, NODE_TOP, '0, '0, '0);
    push_request(CMD_CNT, 8'd7, '0, '0, '0);               // broadcast is no match
    push_request(CMD_NODE, '0, '0, ID_TOP, '0);
    push_request(CMD_NODE, '0, '0, ID_TOP, IDX_TOP);       // beyond the count
    push_request(CMD_NODE, NODE_TOP, '0, '0, '0);
    push_request(CMD_SAVE, 8'd3, 8'd7, '0, '0);            // same id, second entry
    push_request(CMD_ACK, 8'd7, '0, '0, '0);               // lands on one of two
    push_request(CMD_CNT, 8'd7, '0, '0, '0);
    push_request(CMD_NODE, 8'd7, '0, '0, '0);

    push_flood();
    push_random(RANDOM_PER_PHASE);
    wait_idle();

    write_broadcast('0);
    push_random(RANDOM_PER_PHASE);
    wait_idle();

    write_broadcast(NODE_W'($urandom_range(1, 254)));
    push_flood();
    push_random(RANDOM_PER_PHASE);
    wait_idle();

    write_broadcast(NODE_TOP);
    push_random(RANDOM_PER_PHASE);
    wait_idle();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
